FILE: rtl/d_ary_min_heap_defines.svh
// Assertion macros shared by the heap checker.
`ifndef D_ARY_MIN_HEAP_DEFINES_SVH
`define D_ARY_MIN_HEAP_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define DAH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap check failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define DAH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap check failed");
`endif

FILE: rtl/dah_pkg.sv
// Package with the types and constants of the d-ary min-heap.
package dah_pkg;
  localparam int DefArity    = 4;
  localparam int DefCapacity = 1024;
  localparam int SlotW  = 10;
  localparam int CountW = 11;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_DELETE   = 3'd1,
    FN_FINDPAIR = 3'd2,
    FN_FINDVAL  = 3'd3,
    FN_READMIN  = 3'd4,
    FN_READIDX  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [31:0] key;
    logic [15:0]       payload;
    logic [SlotW-1:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   result_slot;
    logic               found;
    logic signed [31:0] result_key;
    logic [15:0]        result_payload;
    logic [CountW-1:0]  entry_count;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        pay;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_DN_SWAP,
    S_DEL_RD, S_DEL_CHK, S_SCAN, S_RD_WAIT, S_OUT
  } state_t;
endpackage

FILE: rtl/d_ary_min_heap.sv
// Top level of the d-ary min-heap priority queue.
// The heap lies in one single-port-read, single-port-write synchronous memory
// of CAPACITY entries with a registered read port; one transaction is
// processed at a time. An insert writes the new entry at the end and climbs
// while its parent holds a larger key. A delete of the last slot only drops
// the count; otherwise it reads the last entry and the parent, then sifts up
// or down, with children read one per cycle through the memory read port.
// Searches read one entry per cycle until a hit or the last entry.
// A finished result waits until the output register is free; the output
// register holds a stalled result unchanged.
// No clearing pass is needed after reset: only slots below the count are read.
module d_ary_min_heap #(
  parameter int ARITY    = dah_pkg::DefArity,
  parameter int CAPACITY = dah_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dah_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dah_pkg::out_item_t out_data
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + $clog2(ARITY) + 1;
  // Reciprocal of ARITY for the parent slot; exact for every slot below 2**CW.
  localparam int RSH = CW + $clog2(ARITY);
  localparam int RCP = (2**RSH + ARITY - 1) / ARITY;
  localparam int PW  = CW + RSH + 1;

  // Heap memory.
  dah_pkg::entry_t mem [CAPACITY];
  logic [AW-1:0]   rd_addr;
  logic            wr_en, wr2_en;
  logic [AW-1:0]   wr_addr;
  dah_pkg::entry_t wr_data, rd_data_r;

  dah_pkg::state_t state_r, state_nxt;
  dah_pkg::in_item_t req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;       // current slot of the moving entry
  logic [CW-1:0] par_r, par_nxt;       // parent, scanned child or searched slot
  logic [CW-1:0] best_r, best_nxt;
  logic [CW-1:0] end_r, end_nxt;
  dah_pkg::entry_t cur_r, cur_nxt;     // moving entry
  dah_pkg::entry_t bent_r, bent_nxt;   // best child entry
  dah_pkg::out_item_t res_r, res_nxt;
  dah_pkg::out_item_t obuf_r, obuf_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [XW-1:0] first_w;
  logic [PW-1:0] pprod_w;
  logic [CW-1:0] parent_w;
  logic          scan_hit;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // The parent slot is found by reciprocal multiplication.
  assign pprod_w  = PW'(idx_r - 1'b1) * PW'(RCP);
  assign parent_w = CW'(pprod_w >> RSH);
  assign first_w  = XW'(idx_r) * XW'(ARITY) + XW'(1);
  assign scan_hit = (rd_data_r.pay == req_r.payload) &&
                    (req_r.func == 3'(dah_pkg::FN_FINDVAL) || rd_data_r.key == req_r.key);
  assign wr2_en   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dah_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    par_r  <= par_nxt;
    best_r <= best_nxt;
    end_r  <= end_nxt;
    cur_r  <= cur_nxt;
    bent_r <= bent_nxt;
    res_r  <= res_nxt;
    obuf_r <= obuf_nxt;
  end

  // Next-state and datapath logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r; count_nxt = count_r; idx_nxt = idx_r; par_nxt = par_r;
    best_nxt = best_r; end_nxt = end_r; cur_nxt = cur_r; bent_nxt = bent_r;
    res_nxt = res_r; obuf_nxt = obuf_r; out_valid_nxt = out_valid_r;
    rd_addr = AW'(par_r); wr_en = wr2_en; wr_addr = AW'(idx_r); wr_data = cur_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      dah_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_nxt = in_data;
          res_nxt = '0;
          state_nxt = dah_pkg::S_DECODE;
        end
      end
      dah_pkg::S_DECODE: begin
        state_nxt = dah_pkg::S_OUT;
        case (req_r.func)
          3'(dah_pkg::FN_INSERT): begin
            if (count_r >= CW'(CAPACITY)) res_nxt.status = dah_pkg::ST_FULL;
            else begin
              cur_nxt = '{key: req_r.key, pay: req_r.payload};
              idx_nxt = count_r;
              count_nxt = count_r + 1'b1;
              state_nxt = dah_pkg::S_UP_RD;
            end
          end
          3'(dah_pkg::FN_DELETE): begin
            if (CW'(req_r.slot) >= count_r) res_nxt.status = dah_pkg::ST_RANGE;
            else begin
              count_nxt = count_r - 1'b1;
              idx_nxt = CW'(req_r.slot);
              par_nxt = count_r - 1'b1;
              rd_addr = AW'(count_r - 1'b1);
              state_nxt = dah_pkg::S_DEL_RD;
            end
          end
          3'(dah_pkg::FN_FINDPAIR), 3'(dah_pkg::FN_FINDVAL): begin
            par_nxt = '0;
            rd_addr = '0;
            if (count_r != '0) state_nxt = dah_pkg::S_SCAN;
          end
          3'(dah_pkg::FN_READMIN), 3'(dah_pkg::FN_READIDX): begin
            rd_addr = (req_r.func == 3'(dah_pkg::FN_READMIN)) ? '0 : AW'(req_r.slot);
            if ((req_r.func == 3'(dah_pkg::FN_READMIN) && count_r == '0) ||
                (req_r.func == 3'(dah_pkg::FN_READIDX) && CW'(req_r.slot) >= count_r))
              res_nxt.status = dah_pkg::ST_RANGE;
            else state_nxt = dah_pkg::S_RD_WAIT;
          end
          default: res_nxt.status = dah_pkg::ST_RANGE;
        endcase
      end
      dah_pkg::S_RD_WAIT: begin
        res_nxt.result_key = rd_data_r.key;
        res_nxt.result_payload = rd_data_r.pay;
        state_nxt = dah_pkg::S_OUT;
      end
      dah_pkg::S_SCAN: begin
        // rd_data_r holds the entry at par_r.
        if (scan_hit) begin
          res_nxt.found = 1'b1;
          res_nxt.result_slot = dah_pkg::SlotW'(par_r);
          state_nxt = dah_pkg::S_OUT;
        end else if (par_r + 1'b1 >= count_r) begin
          state_nxt = dah_pkg::S_OUT;
        end else begin
          par_nxt = par_r + 1'b1;
          rd_addr = AW'(par_r + 1'b1);
        end
      end
      dah_pkg::S_DEL_RD: begin
        // Last entry arrives; it becomes the moving entry for the freed slot.
        cur_nxt = rd_data_r;
        if (idx_r == count_r) state_nxt = dah_pkg::S_OUT;
        else state_nxt = dah_pkg::S_DEL_CHK;
        wr_en = 1'b0;
        rd_addr = AW'(parent_w);
        par_nxt = parent_w;
      end
      dah_pkg::S_DEL_CHK: begin
        wr_en = 1'b1;
        if (idx_r != '0 && rd_data_r.key > cur_r.key) state_nxt = dah_pkg::S_UP_RD;
        else state_nxt = dah_pkg::S_DN_RD;
      end
      dah_pkg::S_UP_RD: begin
        // Write the moving entry at its slot and, unless at the root, fetch its parent.
        wr_en = 1'b1;
        if (idx_r == '0) begin
          res_nxt.result_slot = '0;
          state_nxt = dah_pkg::S_OUT;
        end else begin
          rd_addr = AW'(parent_w);
          par_nxt = parent_w;
          state_nxt = dah_pkg::S_UP_CMP;
        end
      end
      dah_pkg::S_UP_CMP: begin
        if (rd_data_r.key > cur_r.key) begin
          wr_en = 1'b1; wr_data = rd_data_r; wr_addr = AW'(idx_r);
          idx_nxt = par_r;
          state_nxt = dah_pkg::S_UP_RD;
        end else begin
          // Only an insert reports the final slot.
          if (req_r.func == 3'(dah_pkg::FN_INSERT))
            res_nxt.result_slot = dah_pkg::SlotW'(idx_r);
          state_nxt = dah_pkg::S_OUT;
        end
      end
      dah_pkg::S_DN_RD: begin
        if (first_w >= XW'(count_r)) state_nxt = dah_pkg::S_OUT;
        else begin
          par_nxt = CW'(first_w);
          best_nxt = CW'(first_w);
          end_nxt = (first_w + XW'(ARITY) > XW'(count_r)) ? count_r
                    : CW'(first_w + XW'(ARITY));
          rd_addr = AW'(first_w);
          state_nxt = dah_pkg::S_DN_CMP;
        end
      end
      dah_pkg::S_DN_CMP: begin
        // Children are read one a cycle; keep the smallest, lowest slot first.
        if (par_r == best_r || bent_r.key > rd_data_r.key) begin
          best_nxt = par_r; bent_nxt = rd_data_r;
        end
        if (par_r + 1'b1 >= end_r) state_nxt = dah_pkg::S_DN_SWAP;
        else begin
          par_nxt = par_r + 1'b1;
          rd_addr = AW'(par_r + 1'b1);
        end
      end
      dah_pkg::S_DN_SWAP: begin
        if (cur_r.key > bent_r.key) begin
          wr_en = 1'b1; wr_addr = AW'(idx_r); wr_data = bent_r;
          idx_nxt = best_r;
          state_nxt = dah_pkg::S_DN_RD;
        end else state_nxt = dah_pkg::S_OUT;
      end
      dah_pkg::S_OUT: begin
        // Moving entry's final write (harmless rewrite when already stored).
        if (req_r.func == 3'(dah_pkg::FN_DELETE) && res_r.status == dah_pkg::ST_OK &&
            idx_r < count_r) wr_en = 1'b1;
        // The result moves to the output register once that is free.
        if (!out_valid_r || !out_stall) begin
          obuf_nxt = res_r;
          obuf_nxt.entry_count = dah_pkg::CountW'(count_r);
          out_valid_nxt = 1'b1;
          state_nxt = dah_pkg::S_IDLE;
        end
      end
      default: state_nxt = dah_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != dah_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = obuf_r;
endmodule

FILE: rtl/dah_checker.sv
// Port checker for the d-ary min-heap, with its bind statement.
`include "d_ary_min_heap_defines.svh"
module dah_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dah_pkg::out_item_t out_data
);
  // A stalled result holds.
  `DAH_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // A found result always carries status ok.
  `DAH_ASSERT_IMP(a_found_ok, clk, rst_n, out_valid && out_data.found, out_data.status == dah_pkg::ST_OK)
  // An accepted transaction blocks further input next cycle.
  `DAH_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // The status field never carries the unused fourth code.
  `DAH_ASSERT_IMP(a_st, clk, rst_n, out_valid, out_data.status != 2'd3)
endmodule

bind d_ary_min_heap dah_checker u_dah_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

FILE: bench/testbench.sv
// Self-checking testbench for the d-ary min-heap priority queue.
`timescale 1ns / 1ps

module testbench;
  localparam int Arity    = dah_pkg::DefArity;
  localparam int Capacity = dah_pkg::DefCapacity;
  localparam int WatchdogLimit = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dah_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dah_pkg::out_item_t out_data;

  d_ary_min_heap #(.ARITY(Arity), .CAPACITY(Capacity)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the heap, kept in step with every accepted transaction.
  dah_pkg::entry_t    shadow_heap [Capacity];
  int unsigned        shadow_count;
  dah_pkg::out_item_t pending_results [$];
  int unsigned        error_count;
  int unsigned        sent_count;
  int unsigned        checked_count;
  int unsigned        idle_cycles;
  bit                 rx_idling_on;
  bit                 rx_hold;
  bit                 tx_idling_on;
  bit                 timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    dah_pkg::entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic int unsigned climb_heap(int unsigned i);
    int unsigned p;
    while (i != 0) begin
      p = (i - 1) / Arity;
      if (!(shadow_heap[p].key > shadow_heap[i].key)) break;
      swap_entries(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void sink_heap(int unsigned i);
    int unsigned first;
    int unsigned best;
    int unsigned last;
    forever begin
      first = i * Arity + 1;
      if (first >= shadow_count) return;
      last = first + Arity;
      if (last > shadow_count) last = shadow_count;
      best = first;
      for (int unsigned j = first + 1; j < last; j++)
        if (shadow_heap[best].key > shadow_heap[j].key) best = j;
      if (!(shadow_heap[i].key > shadow_heap[best].key)) return;
      swap_entries(i, best);
      i = best;
    end
  endfunction

  // Applies one transaction to the shadow heap and returns the expected result.
  function automatic dah_pkg::out_item_t apply_heap_op(dah_pkg::in_item_t it);
    dah_pkg::out_item_t r;
    r = '0;
    r.status = dah_pkg::ST_OK;
    case (it.func)
      dah_pkg::FN_INSERT: begin
        if (shadow_count >= Capacity) begin
          r.status = dah_pkg::ST_FULL;
        end else begin
          shadow_heap[shadow_count].key = it.key;
          shadow_heap[shadow_count].pay = it.payload;
          r.result_slot = dah_pkg::SlotW'(climb_heap(shadow_count));
          shadow_count++;
        end
      end
      dah_pkg::FN_DELETE: begin
        if (it.slot >= shadow_count) begin
          r.status = dah_pkg::ST_RANGE;
        end else begin
          shadow_count--;
          shadow_heap[it.slot] = shadow_heap[shadow_count];
          if (it.slot != shadow_count) begin
            if (it.slot != 0 &&
                shadow_heap[(it.slot - 1) / Arity].key > shadow_heap[it.slot].key)
              void'(climb_heap(it.slot));
            else
              sink_heap(it.slot);
          end
        end
      end
      dah_pkg::FN_FINDPAIR, dah_pkg::FN_FINDVAL: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_heap[i].pay == it.payload &&
              (it.func == dah_pkg::FN_FINDVAL || shadow_heap[i].key == it.key)) begin
            r.result_slot = dah_pkg::SlotW'(i);
            r.found = 1'b1;
            break;
          end
        end
      end
      dah_pkg::FN_READMIN: begin
        if (shadow_count == 0) begin
          r.status = dah_pkg::ST_RANGE;
        end else begin
          r.result_key = shadow_heap[0].key;
          r.result_payload = shadow_heap[0].pay;
        end
      end
      dah_pkg::FN_READIDX: begin
        if (it.slot >= shadow_count) begin
          r.status = dah_pkg::ST_RANGE;
        end else begin
          r.result_key = shadow_heap[it.slot].key;
          r.result_payload = shadow_heap[it.slot].pay;
        end
      end
      default: r.status = dah_pkg::ST_RANGE;
    endcase
    r.entry_count = dah_pkg::CountW'(shadow_count);
    return r;
  endfunction

  // Sends one transaction, with an optional random gap first.
  // Valid stays high after acceptance until the next call or a drain drops it.
  task automatic send_op(logic [2:0] func, logic signed [31:0] key,
                         logic [15:0] payload, logic [dah_pkg::SlotW-1:0] slot);
    dah_pkg::in_item_t it;
    int unsigned gap;
    it.func = func;
    it.key = key;
    it.payload = payload;
    it.slot = slot;
    if (tx_idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_heap_op(it));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Receiver stall pattern: random bursts, or a long hold when asked.
  initial begin
    int unsigned burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_stall <= 1'b1;
        for (int unsigned c = 0; c < 400; c++) @(posedge clk);
        out_stall <= 1'b0;
        rx_hold = 1'b0;
      end else if (rx_idling_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    dah_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %p", out_data);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (out_data.result_slot !== exp_r.result_slot) begin
          $error("result_slot expected %0d actual %0d", exp_r.result_slot,
                 out_data.result_slot);
          error_count++;
        end
        if (out_data.found !== exp_r.found) begin
          $error("found expected %0d actual %0d", exp_r.found, out_data.found);
          error_count++;
        end
        if (out_data.result_key !== exp_r.result_key) begin
          $error("result_key expected %0d actual %0d", exp_r.result_key,
                 out_data.result_key);
          error_count++;
        end
        if (out_data.result_payload !== exp_r.result_payload) begin
          $error("result_payload expected %0d actual %0d", exp_r.result_payload,
                 out_data.result_payload);
          error_count++;
        end
        if (out_data.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                 out_data.entry_count);
          error_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  // Random key, often from a small set or the extremes so that ties and searches hit often.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_payload();
    if ($urandom_range(0, 2) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 31));
  endfunction

  function automatic logic [dah_pkg::SlotW-1:0] pick_slot();
    if ($urandom_range(0, 4) == 0) return dah_pkg::SlotW'($urandom());
    if (shadow_count == 0) return '0;
    return dah_pkg::SlotW'($urandom_range(0, shadow_count - 1));
  endfunction

  // Extremes of every field, every operation and the empty-heap cases.
  task automatic test_directed();
    send_op(dah_pkg::FN_READMIN, 0, 0, 0);
    send_op(dah_pkg::FN_READIDX, 0, 0, 0);
    send_op(dah_pkg::FN_DELETE, 0, 0, 0);
    send_op(dah_pkg::FN_FINDVAL, 0, 0, 0);
    send_op(dah_pkg::FN_FINDPAIR, 0, 0, 0);
    send_op(dah_pkg::FN_INSERT, 32'sh7fff_ffff, 16'hffff, 10'h3ff);
    send_op(dah_pkg::FN_INSERT, 32'sh8000_0000, 16'h0000, 0);
    send_op(dah_pkg::FN_INSERT, 5, 16'h1234, 0);
    send_op(dah_pkg::FN_INSERT, 5, 16'h1235, 0);
    send_op(dah_pkg::FN_INSERT, -1, 16'h5555, 0);
    send_op(dah_pkg::FN_INSERT, 3, 16'haaaa, 0);
    send_op(dah_pkg::FN_READMIN, 0, 0, 0);
    send_op(dah_pkg::FN_FINDPAIR, 5, 16'h1235, 0);
    send_op(dah_pkg::FN_FINDPAIR, 6, 16'h1235, 0);
    send_op(dah_pkg::FN_FINDVAL, 0, 16'hffff, 0);
    send_op(dah_pkg::FN_READIDX, 0, 0, 5);
    send_op(dah_pkg::FN_READIDX, 0, 0, 6);
    send_op(dah_pkg::FN_READIDX, 0, 0, 10'h3ff);
    send_op(dah_pkg::FN_DELETE, 0, 0, 5);
    send_op(dah_pkg::FN_DELETE, 0, 0, 0);
    send_op(dah_pkg::FN_DELETE, 0, 0, 10'h3ff);
    send_op(3'd6, 32'sh7fff_ffff, 16'hffff, 10'h3ff);
    send_op(3'd7, 0, 0, 0);
    send_op(dah_pkg::FN_DELETE, 0, 0, 1);
    wait_drained();
  endtask

  // Fills the heap to capacity, tries one more insert, then deletes, mostly from the root.
  task automatic test_full_heap();
    while (shadow_count < Capacity)
      send_op(dah_pkg::FN_INSERT, pick_key(), pick_payload(), 0);
    send_op(dah_pkg::FN_INSERT, 0, 0, 0);
    send_op(dah_pkg::FN_READIDX, 0, 0, 10'h3ff);
    send_op(dah_pkg::FN_DELETE, 0, 0, 10'h3ff);
    send_op(dah_pkg::FN_INSERT, pick_key(), pick_payload(), 0);
    for (int unsigned k = 0; k < 100; k++) send_op(dah_pkg::FN_DELETE, 0, 0, 0);
    wait_drained();
  endtask

  // Random mix weighted toward inserts so a small heap holds a few dozen entries.
  task automatic test_random(int unsigned n);
    int unsigned pick;
    logic [2:0] fn;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && shadow_count < 60) fn = dah_pkg::FN_INSERT;
      else if (pick < 55) fn = dah_pkg::FN_DELETE;
      else if (pick < 65) fn = dah_pkg::FN_FINDPAIR;
      else if (pick < 75) fn = dah_pkg::FN_FINDVAL;
      else if (pick < 85) fn = dah_pkg::FN_READMIN;
      else if (pick < 97) fn = dah_pkg::FN_READIDX;
      else fn = 3'($urandom_range(6, 7));
      send_op(fn, pick_key(), pick_payload(), pick_slot());
    end
    wait_drained();
  endtask

  // Long receiver hold while the sender keeps offering work.
  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int unsigned k = 0; k < 20; k++) send_op(dah_pkg::FN_READMIN, 0, 0, 0);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    shadow_count = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    rx_hold = 1'b0;
    rx_idling_on = 1'b1;
    tx_idling_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    test_backpressure();
    test_full_heap();
    test_random(200);
    // Last stretch runs without idling on either side.
    rx_idling_on = 1'b0;
    tx_idling_on = 1'b0;
    test_random(180);
    repeat (100) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results, including a full heap,",
             sent_count, checked_count);
    $display("empty-heap errors, invalid functions and a long output hold.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
